### design/wualu_pkg.sv
// package for the 128-bit unsigned alu
// opcode type and operand widths, used by the interfaces, the top level and the checker
// no dependencies
package wualu_pkg;

  localparam int HALF_W  = 64;
  localparam int WORD_W  = 2 * HALF_W;
  localparam int LIMB_W  = 32;
  localparam int SHAMT_W = 8;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_MUL = 3'd1,
    OP_XOR = 3'd2,
    OP_AND = 3'd3,
    OP_OR  = 3'd4,
    OP_SHR = 3'd5,
    OP_SHL = 3'd6,
    OP_EQ  = 3'd7
  } op_t;

endpackage

### design/wualu_if.sv
// valid/ready channel interfaces for the 128-bit unsigned alu
// operand channel and result channel, each with source and sink modports
// depends on wualu_pkg
interface wualu_in_if;
  import wualu_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [2:0]           opcode;
  logic [HALF_W-1:0]    a_high;
  logic [HALF_W-1:0]    a_low;
  logic [HALF_W-1:0]    b_high;
  logic [HALF_W-1:0]    b_low;
  logic [SHAMT_W-1:0]   shift_amount;

  modport source (output valid, output opcode, output a_high, output a_low,
                  output b_high, output b_low, output shift_amount, input ready);
  modport sink   (input valid, input opcode, input a_high, input a_low,
                  input b_high, input b_low, input shift_amount, output ready);
endinterface

interface wualu_out_if;
  import wualu_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [HALF_W-1:0]    r_high;
  logic [HALF_W-1:0]    r_low;
  logic                 is_equal;

  modport source (output valid, output r_high, output r_low, output is_equal,
                  input ready);
  modport sink   (input valid, input r_high, input r_low, input is_equal,
                  output ready);
endinterface

### design/wide_unsigned_alu_128.sv
// 128-bit unsigned alu: add, low-128 multiply, xor, and, or, shifts, equality compare
// an accepted operand passes through the stage 1, stage 2 and stage 3 registers to the result channel
// throughput: one item per cycle unless a low out_ch.ready stalls it; the multiplier is split into 32x32 partial
// products (stage 1), partial-sum combining (stage 2) and the final high add (stage 3)
// each stage advances when the stage after it is empty or moving on
// reset (rst_n low, synchronous) clears the valid bits of all three stages
module wide_unsigned_alu_128 (
  input  logic         clk,
  input  logic         rst_n,
  wualu_in_if.sink     in_ch,
  wualu_out_if.source  out_ch
);
  import wualu_pkg::*;

  logic en1, en2, en3;

  // stage 1 registers
  logic                v1_r;
  op_t                 op1_r;
  logic [HALF_W-1:0]   p00_r, p01_r, p10_r, p11_r;
  logic [HALF_W-1:0]   q00_r, s00_r;
  logic [LIMB_W-1:0]   q01_r, q10_r, s01_r, s10_r;
  logic [WORD_W-1:0]   alt1_r;
  logic                eq1_r;

  // stage 2 registers
  logic                v2_r;
  op_t                 op2_r;
  logic [HALF_W-1:0]   lo2_r, ph2_r, cross2_r;
  logic [WORD_W-1:0]   alt2_r;
  logic                eq2_r;

  // stage 3 (output) registers
  logic                v3_r;
  logic [HALF_W-1:0]   rh3_r, rl3_r;
  logic                eq3_r;

  // stage 1 next values
  op_t                 op1_nxt;
  logic [WORD_W-1:0]   a_w, b_w;
  logic [HALF_W-1:0]   p00_nxt, p01_nxt, p10_nxt, p11_nxt, q00_nxt, s00_nxt;
  logic [LIMB_W-1:0]   q01_nxt, q10_nxt, s01_nxt, s10_nxt;
  logic [WORD_W-1:0]   alt1_nxt;
  logic                eq1_nxt;

  // stage 2 next values
  logic [HALF_W-1:0]   mid;
  logic [HALF_W-1:0]   lo2_nxt, ph2_nxt, cross2_nxt;

  // stage 3 next values
  logic [HALF_W-1:0]   rh3_nxt, rl3_nxt;

  assign en3 = !v3_r || out_ch.ready;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;

  assign in_ch.ready     = en1;
  assign out_ch.valid    = v3_r;
  assign out_ch.r_high   = rh3_r;
  assign out_ch.r_low    = rl3_r;
  assign out_ch.is_equal = eq3_r;

  // stage 1: partial products and the add, bitwise, shift and compare operations
  assign op1_nxt = op_t'(in_ch.opcode);
  assign a_w     = {in_ch.a_high, in_ch.a_low};
  assign b_w     = {in_ch.b_high, in_ch.b_low};

  // al * bl, full 128 bits
  assign p00_nxt = {{LIMB_W{1'b0}}, in_ch.a_low[LIMB_W-1:0]}
                 * {{LIMB_W{1'b0}}, in_ch.b_low[LIMB_W-1:0]};
  assign p01_nxt = {{LIMB_W{1'b0}}, in_ch.a_low[LIMB_W-1:0]}
                 * {{LIMB_W{1'b0}}, in_ch.b_low[HALF_W-1:LIMB_W]};
  assign p10_nxt = {{LIMB_W{1'b0}}, in_ch.a_low[HALF_W-1:LIMB_W]}
                 * {{LIMB_W{1'b0}}, in_ch.b_low[LIMB_W-1:0]};
  assign p11_nxt = {{LIMB_W{1'b0}}, in_ch.a_low[HALF_W-1:LIMB_W]}
                 * {{LIMB_W{1'b0}}, in_ch.b_low[HALF_W-1:LIMB_W]};

  // cross terms al * bh and ah * bl, low 64 bits only
  assign q00_nxt = {{LIMB_W{1'b0}}, in_ch.a_low[LIMB_W-1:0]}
                 * {{LIMB_W{1'b0}}, in_ch.b_high[LIMB_W-1:0]};
  assign q01_nxt = in_ch.a_low[LIMB_W-1:0] * in_ch.b_high[HALF_W-1:LIMB_W];
  assign q10_nxt = in_ch.a_low[HALF_W-1:LIMB_W] * in_ch.b_high[LIMB_W-1:0];
  assign s00_nxt = {{LIMB_W{1'b0}}, in_ch.a_high[LIMB_W-1:0]}
                 * {{LIMB_W{1'b0}}, in_ch.b_low[LIMB_W-1:0]};
  assign s01_nxt = in_ch.a_high[LIMB_W-1:0] * in_ch.b_low[HALF_W-1:LIMB_W];
  assign s10_nxt = in_ch.a_high[HALF_W-1:LIMB_W] * in_ch.b_low[LIMB_W-1:0];

  always_comb begin
    alt1_nxt = '0;
    eq1_nxt  = 1'b0;
    case (op1_nxt)
      OP_ADD: alt1_nxt = a_w + b_w;
      OP_XOR: alt1_nxt = a_w ^ b_w;
      OP_AND: alt1_nxt = a_w & b_w;
      OP_OR:  alt1_nxt = a_w | b_w;
      OP_SHR: begin
        if (!in_ch.shift_amount[SHAMT_W-1]) begin
          alt1_nxt = a_w >> in_ch.shift_amount[SHAMT_W-2:0];
        end
      end
      OP_SHL: begin
        if (!in_ch.shift_amount[SHAMT_W-1]) begin
          alt1_nxt = a_w << in_ch.shift_amount[SHAMT_W-2:0];
        end
      end
      OP_EQ:  eq1_nxt = (a_w == b_w);
      default: alt1_nxt = '0;
    endcase
  end

  // stage 2: fold partial products
  assign mid = {{LIMB_W{1'b0}}, p00_r[HALF_W-1:LIMB_W]}
             + {{LIMB_W{1'b0}}, p01_r[LIMB_W-1:0]}
             + {{LIMB_W{1'b0}}, p10_r[LIMB_W-1:0]};
  assign lo2_nxt = {mid[LIMB_W-1:0], p00_r[LIMB_W-1:0]};
  assign ph2_nxt = p11_r
                 + {{LIMB_W{1'b0}}, p01_r[HALF_W-1:LIMB_W]}
                 + {{LIMB_W{1'b0}}, p10_r[HALF_W-1:LIMB_W]}
                 + {{LIMB_W{1'b0}}, mid[HALF_W-1:LIMB_W]};
  assign cross2_nxt = q00_r + s00_r
                    + {LIMB_W'(q01_r + q10_r + s01_r + s10_r), {LIMB_W{1'b0}}};

  // stage 3: final high add and result select
  always_comb begin
    if (op2_r == OP_MUL) begin
      rh3_nxt = ph2_r + cross2_r;
      rl3_nxt = lo2_r;
    end else begin
      rh3_nxt = alt2_r[WORD_W-1:HALF_W];
      rl3_nxt = alt2_r[HALF_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (en1) begin
        v1_r <= in_ch.valid;
      end
      if (en2) begin
        v2_r <= v1_r;
      end
      if (en3) begin
        v3_r <= v2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      op1_r  <= op1_nxt;
      p00_r  <= p00_nxt;
      p01_r  <= p01_nxt;
      p10_r  <= p10_nxt;
      p11_r  <= p11_nxt;
      q00_r  <= q00_nxt;
      q01_r  <= q01_nxt;
      q10_r  <= q10_nxt;
      s00_r  <= s00_nxt;
      s01_r  <= s01_nxt;
      s10_r  <= s10_nxt;
      alt1_r <= alt1_nxt;
      eq1_r  <= eq1_nxt;
    end
    if (en2) begin
      op2_r    <= op1_r;
      lo2_r    <= lo2_nxt;
      ph2_r    <= ph2_nxt;
      cross2_r <= cross2_nxt;
      alt2_r   <= alt1_r;
      eq2_r    <= eq1_r;
    end
    if (en3) begin
      rh3_r <= rh3_nxt;
      rl3_r <= rl3_nxt;
      eq3_r <= eq2_r;
    end
  end

endmodule

### design/wualu_checker.sv
// port-level checker for the 128-bit unsigned alu
// watches the operand and result channels of wide_unsigned_alu_128; bound below
// depends on wualu_pkg
module wualu_props (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [wualu_pkg::HALF_W-1:0] r_high,
  input logic [wualu_pkg::HALF_W-1:0] r_low,
  input logic                        is_equal
);
  import wualu_pkg::*;

  // no result leaves the block right after a reset cycle
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a stalled result holds until its transfer
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(r_high) && $stable(r_low)
      && $stable(is_equal))
    else $error("stalled result changed");

  // an empty output stage means the pipeline can take an item
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output stage");

  // a set compare flag comes only with a zero result
  a_eq_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && is_equal |-> r_high == '0 && r_low == '0)
    else $error("compare flag with nonzero result");

endmodule

bind wide_unsigned_alu_128 wualu_props u_wualu_props (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .r_high    (out_ch.r_high),
  .r_low     (out_ch.r_low),
  .is_equal  (out_ch.is_equal)
);

### bench/wualu_checker.sv
`timescale 1ns / 100ps
// result checker for the 128-bit unsigned alu: predicts each operand transfer
// and compares every result transfer against the oldest prediction
// depends on wualu_pkg and the channel interfaces in wualu_if
module wualu_checker (
  input  logic  clk,
  input  logic  rst_n,
  wualu_in_if   in_mon,
  wualu_out_if  out_mon,
  output int    n_errors,
  output int    n_checked
);
  import wualu_pkg::*;

  typedef struct packed {
    logic [HALF_W-1:0] r_high;
    logic [HALF_W-1:0] r_low;
    logic              is_equal;
  } alu_result_t;

  alu_result_t alu_results_q[$];
  alu_result_t want;

  function automatic alu_result_t alu_op_result(input op_t op,
                                                input logic [HALF_W-1:0] ah, al, bh, bl,
                                                input logic [SHAMT_W-1:0] sh);
    logic [WORD_W-1:0] a;
    logic [WORD_W-1:0] b;
    logic [WORD_W-1:0] r;
    alu_result_t res;
    a = {ah, al};
    b = {bh, bl};
    r = '0;
    res.is_equal = 1'b0;
    case (op)
      OP_ADD: r = a + b;
      OP_MUL: r = a * b;
      OP_XOR: r = a ^ b;
      OP_AND: r = a & b;
      OP_OR:  r = a | b;
      OP_SHR: r = (sh < SHAMT_W'(WORD_W)) ? a >> sh : '0;
      OP_SHL: r = (sh < SHAMT_W'(WORD_W)) ? a << sh : '0;
      OP_EQ:  res.is_equal = (a == b);
      default: ;
    endcase
    res.r_high = r[WORD_W-1:HALF_W];
    res.r_low  = r[HALF_W-1:0];
    return res;
  endfunction

  task automatic check_field(input string name, input logic [HALF_W-1:0] exp_v,
                             input logic [HALF_W-1:0] got_v);
    if (got_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, got_v);
      n_errors++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      alu_results_q.delete();
      n_errors  = 0;
      n_checked = 0;
    end else begin
      if (in_mon.valid && in_mon.ready)
        alu_results_q.push_back(alu_op_result(op_t'(in_mon.opcode), in_mon.a_high,
                                              in_mon.a_low, in_mon.b_high, in_mon.b_low,
                                              in_mon.shift_amount));
      if (out_mon.valid && out_mon.ready) begin
        if (alu_results_q.size() == 0) begin
          $display("%0t: unexpected result, expected none actual %h_%h eq %b", $time,
                   out_mon.r_high, out_mon.r_low, out_mon.is_equal);
          n_errors++;
        end else begin
          want = alu_results_q.pop_front();
          check_field("r_high", want.r_high, out_mon.r_high);
          check_field("r_low", want.r_low, out_mon.r_low);
          check_field("is_equal", HALF_W'(want.is_equal), HALF_W'(out_mon.is_equal));
          n_checked++;
        end
      end
    end
  end

endmodule

### bench/tb_wide_unsigned_alu_128.sv
`timescale 1ns / 100ps
// top of the 128-bit unsigned alu bench: clock, reset, operand stimulus,
// result back-pressure and the verdict
// depends on wualu_pkg, wualu_if, wide_unsigned_alu_128 and wualu_checker
module tb_wide_unsigned_alu_128;
  import wualu_pkg::*;

  localparam int N_RANDOM    = 1880;
  localparam int HOLD_AT     = 300;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_AT    = 700;
  localparam int QUIET_AT    = 1600;
  localparam int CYCLE_LIMIT = 400000;

  localparam logic [63:0] ONES  = '1;
  localparam logic [63:0] PAT_A = 64'h8000_0000_0000_0001;
  localparam logic [63:0] PAT_B = 64'hf0f0_a5a5_3c3c_9669;
  localparam logic [63:0] PAT_C = 64'h0ff0_5a5a_c3c3_6996;

  logic clk;
  logic rst_n;
  int   n_sent;
  int   n_errors;
  int   n_checked;
  int   cycle_count;
  bit   hold_done;
  bit   no_idle;

  wualu_in_if  in_ch();
  wualu_out_if out_ch();

  wide_unsigned_alu_128 i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  wualu_checker i_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_mon    (in_ch),
    .out_mon   (out_ch),
    .n_errors  (n_errors),
    .n_checked (n_checked)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic logic [63:0] rand_half();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return 64'd1 << $urandom_range(0, 63);
      3: return 64'($urandom_range(0, 255));
      4: return $urandom_range(0, 1) ? 64'h0000_0000_ffff_ffff : 64'hffff_ffff_0000_0000;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic send_op(input op_t op, input logic [63:0] ah, al, bh, bl,
                         input logic [7:0] sh);
    in_ch.valid        <= 1'b1;
    in_ch.opcode       <= op;
    in_ch.a_high       <= ah;
    in_ch.a_low        <= al;
    in_ch.b_high       <= bh;
    in_ch.b_low        <= bl;
    in_ch.shift_amount <= sh;
    do @(posedge clk); while (!in_ch.ready);
    n_sent++;
  endtask

  task automatic send_random();
    op_t op;
    logic [63:0] ah, al, bh, bl;
    logic [7:0] sh;
    op = op_t'($urandom_range(0, 7));
    ah = rand_half();
    al = rand_half();
    bh = rand_half();
    bl = rand_half();
    if (op == OP_EQ && $urandom_range(0, 1)) begin
      bh = ah;
      bl = al;
      case ($urandom_range(0, 2))
        1: bl = bl ^ (64'd1 << $urandom_range(0, 63));
        2: bh = bh ^ (64'd1 << $urandom_range(0, 63));
        default: ;
      endcase
    end
    sh = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(128, 255))
                                     : 8'($urandom_range(0, 127));
    send_op(op, ah, al, bh, bl, sh);
  endtask

  task automatic wait_drained();
    while (n_checked < n_sent) @(posedge clk);
  endtask

  // receiver: random ready bursts, one long hold-off once HOLD_AT items are sent
  initial begin
    out_ch.ready <= 1'b0;
    hold_done = 1'b0;
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      if (!hold_done && n_sent >= HOLD_AT) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else if (!no_idle && $urandom_range(0, 7) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  initial begin
    rst_n              <= 1'b0;
    in_ch.valid        <= 1'b0;
    in_ch.opcode       <= OP_ADD;
    in_ch.a_high       <= '0;
    in_ch.a_low        <= '0;
    in_ch.b_high       <= '0;
    in_ch.b_low        <= '0;
    in_ch.shift_amount <= '0;
    n_sent      = 0;
    no_idle     = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // add: full wrap, carry across halves, zero
    send_op(OP_ADD, ONES, ONES, 64'd0, 64'd1, 8'd0);
    send_op(OP_ADD, 64'd0, ONES, 64'd0, 64'd1, 8'd0);
    send_op(OP_ADD, 64'd0, 64'd0, 64'd0, 64'd0, 8'd0);
    // mul: all ones, limb carries, cross terms
    send_op(OP_MUL, ONES, ONES, ONES, ONES, 8'd0);
    send_op(OP_MUL, 64'd0, ONES, 64'd0, ONES, 8'd0);
    send_op(OP_MUL, PAT_B, PAT_A, PAT_C, PAT_B, 8'd0);
    // bitwise
    send_op(OP_XOR, PAT_B, PAT_C, PAT_C, PAT_B, 8'd0);
    send_op(OP_AND, PAT_B, PAT_C, ONES, PAT_B, 8'd0);
    send_op(OP_OR, PAT_A, 64'd0, PAT_C, PAT_B, 8'd0);
    // shifts, b is ignored
    send_op(OP_SHR, PAT_A, PAT_B, ONES, ONES, 8'd0);
    send_op(OP_SHR, PAT_A, PAT_B, ONES, ONES, 8'd1);
    send_op(OP_SHR, PAT_A, PAT_B, PAT_C, 64'd0, 8'd63);
    send_op(OP_SHR, PAT_A, PAT_B, 64'd0, PAT_C, 8'd64);
    send_op(OP_SHR, ONES, ONES, ONES, ONES, 8'd127);
    send_op(OP_SHR, ONES, ONES, ONES, ONES, 8'd128);
    send_op(OP_SHL, PAT_A, PAT_A, ONES, ONES, 8'd0);
    send_op(OP_SHL, PAT_A, PAT_A, ONES, ONES, 8'd1);
    send_op(OP_SHL, PAT_C, PAT_B, PAT_C, 64'd0, 8'd63);
    send_op(OP_SHL, PAT_C, PAT_B, 64'd0, PAT_C, 8'd64);
    send_op(OP_SHL, ONES, ONES, ONES, ONES, 8'd127);
    send_op(OP_SHL, ONES, ONES, ONES, ONES, 8'd255);
    // compare: equal, low differs, high differs
    send_op(OP_EQ, PAT_B, PAT_C, PAT_B, PAT_C, 8'd255);
    send_op(OP_EQ, PAT_B, PAT_C, PAT_B, PAT_C ^ 64'd1, 8'd0);
    send_op(OP_EQ, PAT_A, ONES, 64'd0, ONES, 8'd0);

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == QUIET_AT)
        no_idle = 1'b1;
      if (i == DRAIN_AT) begin
        in_ch.valid <= 1'b0;
        wait_drained();
      end else if (!no_idle && $urandom_range(0, 5) == 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
      send_random();
    end
    in_ch.valid <= 1'b0;

    wait_drained();
    repeat (10) @(posedge clk);
    if (n_errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
